>>> hw/rtl/pidc_pkg.sv
// Shared widths, register indexes and types of the PID controller.
`default_nettype none
package pidc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam int OUT_W     = 32;
   localparam int LIMIT_W   = 15;

   // error is one bit wider than a sample, the error difference one more
   localparam int ERR_W  = SAMPLE_W + 1;
   localparam int DIFF_W = SAMPLE_W + 2;
   localparam int INTG_W = LIMIT_W + 1;
   // weighted sum of the three terms, and that sum times the output gain
   localparam int OPND_W = DIFF_W + GAIN_W + 1;
   localparam int PROD_W = OPND_W + GAIN_W;
   localparam int CNT_W  = $clog2(GAIN_W);

   localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = {LIMIT_W{1'b1}};
   localparam logic [GAIN_W-1:0]  UNITY_GAIN    = GAIN_W'(1) << FRAC_BITS;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = GAIN_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_LIMIT  = 3'd4;

   typedef struct packed {
      logic [GAIN_W-1:0]  total_gain;
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [LIMIT_W-1:0] int_limit;
   } gains_type;

   typedef struct packed {
      logic step;   // take one multiplier digit this cycle
      logic first;  // most significant digit: restart the sum, negative weight
   } mac_ctl_type;

endpackage
`default_nettype wire

>>> hw/rtl/pidc_if.sv
// Request and response channel interfaces of the PID controller.
`default_nettype none
interface pidc_req_if;
   import pidc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] target;
   logic signed [SAMPLE_W-1:0] feedback;
   modport source (output valid, target, feedback, input ready);
   modport sink (input valid, target, feedback, output ready);
endinterface

interface pidc_rsp_if;
   import pidc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] drive;
   logic                    saturated;
   modport source (output valid, drive, saturated, input ready);
   modport sink (input valid, drive, saturated, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pidc_csr.sv
// Gain and limit registers; any write to a known index requests a history clear.
`default_nettype none
module pidc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [pidc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pidc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pidc_pkg::gains_type                   gains,
   output logic                                  hist_clr
);
   import pidc_pkg::*;

   gains_type gains_ff, gains_in;

   always_comb begin
      gains_in = gains_ff;
      hist_clr = 1'b0;
      if (csr_wr_en) begin
         hist_clr = 1'b1;
         case (csr_index)
            CSR_TOTAL_GAIN: gains_in.total_gain = csr_wdata;
            CSR_PROP_GAIN:  gains_in.prop_gain  = csr_wdata;
            CSR_INTEG_GAIN: gains_in.integ_gain = csr_wdata;
            CSR_DERIV_GAIN: gains_in.deriv_gain = csr_wdata;
            CSR_INT_LIMIT:  gains_in.int_limit  = csr_wdata[LIMIT_W-1:0];
            default:        hist_clr = 1'b0;   // unknown index: no effect
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.total_gain <= UNITY_GAIN;
         gains_ff.prop_gain  <= '0;
         gains_ff.integ_gain <= '0;
         gains_ff.deriv_gain <= '0;
         gains_ff.int_limit  <= DEFAULT_LIMIT;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pidc_mac.sv
// Bit-serial multiply-accumulate: up to three operands, one gain bit each per cycle while ctl.step is high.
`default_nettype none
module pidc_mac (
   input  wire logic                                clock,
   input  wire pidc_pkg::mac_ctl_type               ctl,
   input  wire logic signed [pidc_pkg::OPND_W-1:0]  opnd0,
   input  wire logic signed [pidc_pkg::OPND_W-1:0]  opnd1,
   input  wire logic signed [pidc_pkg::OPND_W-1:0]  opnd2,
   input  wire logic [2:0]                          digit,
   output logic signed [pidc_pkg::PROD_W-1:0]       acc
);
   import pidc_pkg::*;

   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] term;

   // MSB first (Horner): acc = 2*acc + selected operands; the top bit
   // of a two's complement gain carries negative weight.
   always_comb begin
      term = (digit[0] ? PROD_W'(opnd0) : '0)
           + (digit[1] ? PROD_W'(opnd1) : '0)
           + (digit[2] ? PROD_W'(opnd2) : '0);
      if (ctl.first) begin
         acc_in = '0 - term;
      end else begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0} + term;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pidc_out.sv
// Output stage: Q.16 to Q.8 shift, saturation to the drive width, result register.
`default_nettype none
module pidc_out (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire logic signed [pidc_pkg::PROD_W-1:0] prod,
   output logic                                    free,
   pidc_rsp_if.source                              rsp
);
   import pidc_pkg::*;

   localparam int SHIFT_W = PROD_W - FRAC_BITS;

   logic signed [SHIFT_W-1:0]       scaled;
   logic [SHIFT_W-OUT_W:0]          upper;
   logic                            in_range;
   logic                            valid_ff, valid_in;
   logic signed [OUT_W-1:0]         drive_ff, drive_in;
   logic                            sat_ff, sat_in;

   always_comb begin
      scaled   = SHIFT_W'(prod >>> FRAC_BITS);
      upper    = scaled[SHIFT_W-1:OUT_W-1];
      in_range = (upper == '0) || (upper == '1);
      free     = !valid_ff || rsp.ready;
      drive_in = drive_ff;
      sat_in   = sat_ff;
      valid_in = valid_ff && !rsp.ready;
      if (load) begin
         valid_in = 1'b1;
         sat_in   = !in_range;
         if (in_range) begin
            drive_in = scaled[OUT_W-1:0];
         end else if (scaled[SHIFT_W-1]) begin
            drive_in = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            drive_in = {1'b0, {(OUT_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.drive     = drive_ff;
   assign rsp.saturated = sat_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pid_controller_int_clamp_unit.sv
// PID controller with integrator clamp: top level, sequencer and history.
//
// Usage:
//  - req carries one item: a target and a feedback sample (signed).
//    rsp carries the result: a saturated Q24.8 drive and a clip flag.
//    Both are valid/ready channels; a transfer happens when both are high.
//  - csr_wr_en/csr_index/csr_wdata write the gain and limit registers
//    (0 total, 1 proportional, 2 integral, 3 derivative, 4 limit). Any
//    write to a known index clears the integrator and previous error.
//    Write only while the block is idle.
//  - One item at a time: the next item is accepted only after the previous
//    result has been loaded into the output register. The sequencer
//    runs PREP, then the shared bit-serial MAC for the three gain terms
//    together (MAC1), then XFER, the MAC for the output gain (MAC2) and FIN.
//  - The result sits in an output register; a stalled receiver does not
//    stop the next item from being accepted and computed. Only the load
//    of the following result waits for the register to drain.
//  - Reset (synchronous, active high) restores the default gains, clears
//    the history and empties the output register.
`default_nettype none
module pid_controller_int_clamp_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pidc_req_if.sink                              req,
   pidc_rsp_if.source                            rsp,
   input  wire logic                             csr_wr_en,
   input  wire logic [pidc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pidc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pidc_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
   localparam logic [2:0] ST_PREP = 3'd1;  // integrator clamp, error difference
   localparam logic [2:0] ST_MAC1 = 3'd2;  // kp*e + ki*I + kd*d, one bit a cycle
   localparam logic [2:0] ST_XFER = 3'd3;  // sum becomes the next multiplicand
   localparam logic [2:0] ST_MAC2 = 3'd4;  // sum * total gain
   localparam logic [2:0] ST_FIN  = 3'd5;  // hand product to the output stage

   gains_type   gains;
   logic        hist_clr;
   mac_ctl_type mac_ctl;
   logic signed [PROD_W-1:0] mac_acc;
   logic        out_free;
   logic        out_load;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W-1:0]  prev_ff, prev_in;
   logic signed [INTG_W-1:0] integ_ff, integ_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [OPND_W-1:0] op0_ff, op0_in;
   logic [GAIN_W-1:0]        kp_sr_ff, kp_sr_in;
   logic [GAIN_W-1:0]        ki_sr_ff, ki_sr_in;
   logic [GAIN_W-1:0]        kd_sr_ff, kd_sr_in;

   logic signed [DIFF_W-1:0] int_sum;
   logic signed [DIFF_W-1:0] lim;

   pidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains),
      .hist_clr  (hist_clr)
   );

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      prev_in  = prev_ff;
      integ_in = integ_ff;
      diff_in  = diff_ff;
      op0_in   = op0_ff;
      kp_sr_in = kp_sr_ff;
      ki_sr_in = ki_sr_ff;
      kd_sr_in = kd_sr_ff;
      mac_ctl  = '{step: 1'b0, first: 1'b0};
      out_load = 1'b0;

      // zero limit means the widest bound
      lim     = (gains.int_limit == '0) ? DIFF_W'(DEFAULT_LIMIT) : DIFF_W'(gains.int_limit);
      int_sum = DIFF_W'(integ_ff) + DIFF_W'(err_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               err_in   = ERR_W'(req.target) - ERR_W'(req.feedback);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (int_sum > lim) begin
               integ_in = INTG_W'(lim);
            end else if (int_sum < -lim) begin
               integ_in = INTG_W'(-lim);
            end else begin
               integ_in = INTG_W'(int_sum);
            end
            diff_in  = DIFF_W'(err_ff) - DIFF_W'(prev_ff);
            prev_in  = err_ff;
            op0_in   = OPND_W'(err_ff);
            kp_sr_in = gains.prop_gain;
            ki_sr_in = gains.integ_gain;
            kd_sr_in = gains.deriv_gain;
            cnt_in   = '0;
            state_in = ST_MAC1;
         end
         ST_MAC1, ST_MAC2: begin
            mac_ctl  = '{step: 1'b1, first: (cnt_ff == '0)};
            kp_sr_in = {kp_sr_ff[GAIN_W-2:0], 1'b0};
            ki_sr_in = {ki_sr_ff[GAIN_W-2:0], 1'b0};
            kd_sr_in = {kd_sr_ff[GAIN_W-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
               state_in = (state_ff == ST_MAC1) ? ST_XFER : ST_FIN;
            end
         end
         ST_XFER: begin
            // second pass: only one operand, the others see zero digits
            op0_in   = mac_acc[OPND_W-1:0];
            kp_sr_in = gains.total_gain;
            ki_sr_in = '0;
            kd_sr_in = '0;
            cnt_in   = '0;
            state_in = ST_MAC2;
         end
         ST_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (hist_clr) begin
         integ_in = '0;
         prev_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      op0_ff   <= op0_in;
      kp_sr_ff <= kp_sr_in;
      ki_sr_ff <= ki_sr_in;
      kd_sr_ff <= kd_sr_in;
   end

   pidc_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .opnd0 (op0_ff),
      .opnd1 (OPND_W'(integ_ff)),
      .opnd2 (OPND_W'(diff_ff)),
      .digit ({kd_sr_ff[GAIN_W-1], ki_sr_ff[GAIN_W-1], kp_sr_ff[GAIN_W-1]}),
      .acc   (mac_acc)
   );

   pidc_out u_out (
      .clock (clock),
      .reset (reset),
      .load  (out_load),
      .prod  (mac_acc),
      .free  (out_free),
      .rsp   (rsp)
   );

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the PID controller with integrator clamp.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidc_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Run parameters
   // ---------------------------------------------------------------------------------------
   localparam int CYCLE_LIMIT   = 600000;  // generous for ~1400 items
   localparam int RAND_PHASES   = 9;
   localparam int PHASE_ITEMS   = 150;
   localparam int DRAIN_CYCLES  = 40;      // quiet tail once all results are back
   localparam int SETTLE_CYCLES = 4;       // quiet cycles before a register write
   localparam int MAX_REPORTS   = 10;

   localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
   localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   // indexes past the last register: the block must ignore writes there
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INT_LIMIT + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [SAMPLE_W-1:0] feedback;
   } sample_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    saturated;
   } drive_item_type;

   // ---------------------------------------------------------------------------------------
   // Clock, reset, block under test
   // ---------------------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   pidc_req_if req ();
   pidc_rsp_if rsp ();

   always #2 clock = ~clock;

   pid_controller_int_clamp_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Controller model: register copy and loop history
   // ---------------------------------------------------------------------------------------
   gains_type               gains;
   logic signed [INTG_W-1:0] integ_sum;
   logic signed [ERR_W-1:0]  last_error;

   sample_type     sample_q [$];   // items waiting to be sent
   drive_item_type drive_q [$];    // predicted results, oldest first

   int          send_idle_pct;
   int          recv_idle_pct;
   int          send_gap;
   int          recv_stall;
   int unsigned cycle_count;
   int unsigned errors;
   drive_item_type want;

   // One control step: error, clamped integrator, PID sum, output gain, saturation.
   // Everything fits in 64 bits (sum < 2^35, times gain < 2^50).
   function automatic drive_item_type control_law(input logic signed [SAMPLE_W-1:0] tgt,
                                                  input logic signed [SAMPLE_W-1:0] fb);
      longint err, lim, isum, acc, scaled;
      drive_item_type r;
      err  = longint'(tgt) - longint'(fb);
      lim  = (gains.int_limit == '0) ? longint'(DEFAULT_LIMIT) : longint'(gains.int_limit);
      isum = longint'(integ_sum) + err;
      if (isum > lim) begin
         isum = lim;
      end else if (isum < -lim) begin
         isum = -lim;
      end
      integ_sum = INTG_W'(isum);
      acc = longint'($signed(gains.prop_gain)) * err
          + longint'($signed(gains.integ_gain)) * isum
          + longint'($signed(gains.deriv_gain)) * (err - longint'(last_error));
      last_error = ERR_W'(err);
      // arithmetic shift: rounds toward minus infinity
      scaled = (acc * longint'($signed(gains.total_gain))) >>> FRAC_BITS;
      r.saturated = 1'b0;
      if (scaled > OUT_MAX) begin
         scaled      = OUT_MAX;
         r.saturated = 1'b1;
      end else if (scaled < OUT_MIN) begin
         scaled      = OUT_MIN;
         r.saturated = 1'b1;
      end
      r.drive = OUT_W'(scaled);
      return r;
   endfunction

   task automatic note_failure(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'(int'($urandom_range(0, 1200)) - 600);
      endcase
   endfunction

   // bit 15 is random in the wide case: the block keeps only 15 bits
   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'd1;
         2:       return 16'h7fff;
         3:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(1, 200));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return SAMPLE_W'(SAMPLE_MIN);
         1:       return SAMPLE_W'(SAMPLE_MAX);
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'(1);
      endcase
   endfunction

   // half of the items loop-like (feedback close to target) so the integrator wanders
   // instead of sitting at its bound; the rest full-range and corners
   function automatic sample_type pick_sample();
      sample_type s;
      int t, f;
      case ($urandom_range(0, 7))
         0: begin
            s.target   = corner_value();
            s.feedback = corner_value();
         end
         1, 2, 3: begin
            s.target   = SAMPLE_W'($urandom);
            s.feedback = SAMPLE_W'($urandom);
         end
         default: begin
            t = int'($signed(SAMPLE_W'($urandom)));
            f = t + int'($urandom_range(0, 600)) - 300;
            if (f > SAMPLE_MAX) f = SAMPLE_MAX;
            if (f < SAMPLE_MIN) f = SAMPLE_MIN;
            s.target   = SAMPLE_W'(t);
            s.feedback = SAMPLE_W'(f);
         end
      endcase
      return s;
   endfunction

   task automatic send(input int t, input int f);
      sample_type s;
      s.target   = SAMPLE_W'(t);
      s.feedback = SAMPLE_W'(f);
      sample_q.push_back(s);
   endtask

   // block idle: nothing queued or offered, every result taken
   task automatic wait_idle();
      while (sample_q.size() != 0 || req.valid || drive_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write; the model follows once the write has landed
   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0]  val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TOTAL_GAIN: gains.total_gain = val;
         CSR_PROP_GAIN:  gains.prop_gain  = val;
         CSR_INTEG_GAIN: gains.integ_gain = val;
         CSR_DERIV_GAIN: gains.deriv_gain = val;
         CSR_INT_LIMIT:  gains.int_limit  = val[LIMIT_W-1:0];
         default: ;
      endcase
      // any known register clears the history, even with an unchanged value
      if (idx <= CSR_INT_LIMIT) begin
         integ_sum  = '0;
         last_error = '0;
      end
   endtask

   task automatic set_all(input logic [CSR_DATA_W-1:0] total, input logic [CSR_DATA_W-1:0] kp,
                          input logic [CSR_DATA_W-1:0] ki, input logic [CSR_DATA_W-1:0] kd,
                          input logic [CSR_DATA_W-1:0] limit);
      set_reg(CSR_TOTAL_GAIN, total);
      set_reg(CSR_PROP_GAIN, kp);
      set_reg(CSR_INTEG_GAIN, ki);
      set_reg(CSR_DERIV_GAIN, kd);
      set_reg(CSR_INT_LIMIT, limit);
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: offers queued items; predicts on every accept
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req.valid && req.ready) begin
            drive_q.push_back(control_law(req.target, req.feedback));
         end
         if (!req.valid || req.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req.valid <= 1'b0;
            end else if (sample_q.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
               // bursts can chain, so gaps land anywhere in the block's cycle
               send_gap  = $urandom_range(1, 15) - 1;
               req.valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
               req.valid    <= 1'b1;
               req.target   <= sample_q[0].target;
               req.feedback <= sample_q[0].feedback;
               void'(sample_q.pop_front());
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: random back-pressure, compares each result with the oldest prediction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (drive_q.size() == 0) begin
               note_failure($sformatf("result with none pending: drive %0d sat %0b",
                                      rsp.drive, rsp.saturated));
            end else begin
               want = drive_q.pop_front();
               if (rsp.drive !== want.drive || rsp.saturated !== want.saturated) begin
                  note_failure($sformatf("drive %0d sat %0b, expected drive %0d sat %0b",
                                         rsp.drive, rsp.saturated, want.drive,
                                         want.saturated));
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            recv_stall = $urandom_range(1, 15) - 1;
            rsp.ready  <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence: reset, directed cases, random phases, drain, verdict
   // ---------------------------------------------------------------------------------------
   initial begin
      req.valid     = 1'b0;
      req.target    = '0;
      req.feedback  = '0;
      rsp.ready     = 1'b0;
      cycle_count   = 0;
      errors        = 0;
      send_idle_pct = 30;
      recv_idle_pct = 20;
      gains         = '{total_gain: UNITY_GAIN, prop_gain: '0, integ_gain: '0,
                        deriv_gain: '0, int_limit: DEFAULT_LIMIT};
      integ_sum     = '0;
      last_error    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset gains: only the zero proportional/integral/derivative path
      send(1000, -1000);
      send(SAMPLE_MAX, SAMPLE_MIN);

      // unity P only, zero limit (selects the full bound); sample extremes
      wait_idle();
      set_all(UNITY_GAIN, UNITY_GAIN, '0, '0, '0);
      send(0, 0);
      send(SAMPLE_MAX, SAMPLE_MIN);
      send(SAMPLE_MIN, SAMPLE_MAX);
      send(SAMPLE_MAX, SAMPLE_MAX);
      send(SAMPLE_MIN, SAMPLE_MIN);
      send(-1, 0);

      // extreme gains: integrator runs into the bound, drive clips both ways
      wait_idle();
      set_all(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, '0);
      repeat (3) send(SAMPLE_MAX, SAMPLE_MIN);
      repeat (3) send(SAMPLE_MIN, SAMPLE_MAX);

      // small bound of 5; then writes to unused indexes must keep the history
      wait_idle();
      set_all(UNITY_GAIN, '0, UNITY_GAIN, UNITY_GAIN, 16'd5);
      send(3, 0);
      send(3, 0);
      send(-1, 0);
      wait_idle();
      set_reg(CSR_SPARE_FIRST, '1);
      set_reg(CSR_SPARE_LAST, '0);
      send(2, 0);
      send(0, 7);

      // same limit again still clears; then a 16-bit limit write truncates to 15
      wait_idle();
      set_reg(CSR_INT_LIMIT, 16'd5);
      send(0, 0);
      send(4, 0);
      wait_idle();
      set_reg(CSR_INT_LIMIT, '1);

      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         if (p == 0) begin
            set_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
         end else if (p == 1) begin
            set_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd1);
         end else begin
            if ($urandom_range(0, 3) != 0) set_reg(CSR_TOTAL_GAIN, pick_gain());
            if ($urandom_range(0, 3) != 0) set_reg(CSR_PROP_GAIN, pick_gain());
            if ($urandom_range(0, 3) != 0) set_reg(CSR_INTEG_GAIN, pick_gain());
            if ($urandom_range(0, 3) != 0) set_reg(CSR_DERIV_GAIN, pick_gain());
            set_reg(CSR_INT_LIMIT, pick_limit());
         end
         // last phase runs flat out; earlier ones mix quiet and busy stretches
         if (p == RAND_PHASES - 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 50);
            recv_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
         end
         repeat (PHASE_ITEMS / 2) sample_q.push_back(pick_sample());
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            set_reg(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                    CSR_DATA_W'($urandom));
         end
         repeat (PHASE_ITEMS - PHASE_ITEMS / 2) sample_q.push_back(pick_sample());
      end

      // drain: all items taken, all results back, then a quiet tail
      while (sample_q.size() != 0 || req.valid) @(negedge clock);
      while (drive_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (drive_q.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", drive_q.size()));
      end
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
